// ===== rtl/core/mplm_pkg.sv =====
// Shared types and constants of the mesh packet latency model.
package mplm_pkg;

  localparam int LEN_W      = 16;
  localparam int FLIT_DIV_W = LEN_W + 3;
  localparam int FLIT_STEPS = FLIT_DIV_W;
  localparam int FLIT_W     = FLIT_DIV_W + 1;
  localparam int CW_W       = 9;
  localparam int RADIX_W    = 9;
  localparam int DIMS_W     = 3;
  localparam int WD_W       = 8;
  localparam int HT_W       = 16;
  localparam int CF_W       = 16;
  localparam int M_W        = WD_W + HT_W;
  localparam int WQ_W       = CF_W + FLIT_W;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIRE_DELAY        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_TIME_Q8       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX             = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENTION_FACTOR = 3'd6;

  typedef struct packed {
    logic valid;
    logic zero;
  } mplm_ctl_t;

endpackage

// ===== rtl/core/mplm_cell.sv =====
// One division step cell of the flit and node digit chain.
module mplm_cell import mplm_pkg::*; #(
  parameter int IDX       = 0,
  parameter int NODE_BITS = 16,
  parameter int MAX_DIMS  = 4,
  parameter int DIST_W    = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ce_i,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic [CW_W-1:0]       width_i,
  input  logic [DIMS_W-1:0]     dims_i,
  input  mplm_ctl_t             ctl_i,
  input  logic [FLIT_DIV_W-1:0] lx_i,
  input  logic [CW_W-1:0]       lr_i,
  input  logic [NODE_BITS-1:0]  sx_i,
  input  logic [NODE_BITS-1:0]  dx_i,
  input  logic [RADIX_W-1:0]    sr_i,
  input  logic [RADIX_W-1:0]    dr_i,
  input  logic [DIST_W-1:0]     dist_i,
  output mplm_ctl_t             ctl_o,
  output logic [FLIT_DIV_W-1:0] lx_o,
  output logic [CW_W-1:0]       lr_o,
  output logic [NODE_BITS-1:0]  sx_o,
  output logic [NODE_BITS-1:0]  dx_o,
  output logic [RADIX_W-1:0]    sr_o,
  output logic [RADIX_W-1:0]    dr_o,
  output logic [DIST_W-1:0]     dist_o
);

  localparam bit FLIT_CELL  = (IDX < FLIT_STEPS);
  localparam bit NODE_CELL  = (IDX < NODE_BITS * MAX_DIMS);
  localparam bit DIGIT_LAST = ((IDX % NODE_BITS) == (NODE_BITS - 1));
  localparam int DIM        = IDX / NODE_BITS;

  mplm_ctl_t             ctl_q;
  logic [FLIT_DIV_W-1:0] lx_d, lx_q;
  logic [CW_W-1:0]       lr_d, lr_q;
  logic [NODE_BITS-1:0]  sx_d, sx_q, dx_d, dx_q;
  logic [RADIX_W-1:0]    sr_d, sr_q, dr_d, dr_q;
  logic [DIST_W-1:0]     dist_d, dist_q;
  logic [CW_W:0]         lt;
  logic [RADIX_W:0]      st, dt;
  logic [RADIX_W-1:0]    step;

  always_comb begin
    lx_d   = lx_i;
    lr_d   = lr_i;
    sx_d   = sx_i;
    dx_d   = dx_i;
    sr_d   = sr_i;
    dr_d   = dr_i;
    dist_d = dist_i;
    step   = '0;
    lt     = {lr_i, lx_i[FLIT_DIV_W-1]};
    st     = {sr_i, sx_i[NODE_BITS-1]};
    dt     = {dr_i, dx_i[NODE_BITS-1]};
    if (FLIT_CELL) begin
      if (lt >= {1'b0, width_i}) begin
        lr_d = CW_W'(lt - {1'b0, width_i});
        lx_d = {lx_i[FLIT_DIV_W-2:0], 1'b1};
      end else begin
        lr_d = lt[CW_W-1:0];
        lx_d = {lx_i[FLIT_DIV_W-2:0], 1'b0};
      end
    end
    if (NODE_CELL) begin
      if (st >= {1'b0, radix_i}) begin
        sr_d = RADIX_W'(st - {1'b0, radix_i});
        sx_d = {sx_i[NODE_BITS-2:0], 1'b1};
      end else begin
        sr_d = st[RADIX_W-1:0];
        sx_d = {sx_i[NODE_BITS-2:0], 1'b0};
      end
      if (dt >= {1'b0, radix_i}) begin
        dr_d = RADIX_W'(dt - {1'b0, radix_i});
        dx_d = {dx_i[NODE_BITS-2:0], 1'b1};
      end else begin
        dr_d = dt[RADIX_W-1:0];
        dx_d = {dx_i[NODE_BITS-2:0], 1'b0};
      end
      if (DIGIT_LAST) begin
        if (sr_d > dr_d) begin
          step = RADIX_W'(radix_i - (sr_d - dr_d));
        end else begin
          step = dr_d - sr_d;
        end
        if (({1'b0, dims_i} > 4'(DIM)) && (radix_i >= 9'd2)) begin
          dist_d = dist_i + DIST_W'(step);
        end
        sr_d = '0;
        dr_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ce_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      lx_q   <= lx_d;
      lr_q   <= lr_d;
      sx_q   <= sx_d;
      dx_q   <= dx_d;
      sr_q   <= sr_d;
      dr_q   <= dr_d;
      dist_q <= dist_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign lx_o   = lx_q;
  assign lr_o   = lr_q;
  assign sx_o   = sx_q;
  assign dx_o   = dx_q;
  assign sr_o   = sr_q;
  assign dr_o   = dr_q;
  assign dist_o = dist_q;

endmodule

// ===== rtl/core/mplm_arith.sv =====
// Multiply, round and saturate back end of the latency model.
module mplm_arith import mplm_pkg::*; #(
  parameter int DIST_W = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ce_i,
  input  logic [WD_W-1:0]       wire_delay_i,
  input  logic [HT_W-1:0]       hop_time_i,
  input  logic [CF_W-1:0]       cf_i,
  input  mplm_ctl_t             ctl_i,
  input  logic [FLIT_DIV_W-1:0] quo_i,
  input  logic [CW_W-1:0]       rem_i,
  input  logic [DIST_W-1:0]     dist_i,
  output logic                  valid_o,
  output logic [OUT_W-1:0]      latency_o,
  output logic [OUT_W-1:0]      contention_o,
  output logic [OUT_W-1:0]      flit_hops_o
);

  localparam int HW    = DIST_W + WQ_W + 1;
  localparam int HH_W  = HW - 32 + M_W;
  localparam int LO_W  = 32 + M_W;
  localparam int SUM_W = HH_W + 9;
  localparam int FS_W  = FLIT_W + 1;
  localparam int FH_W  = FLIT_W + FS_W;

  mplm_ctl_t          ctl_a, ctl_b, ctl_c;
  logic [FLIT_W-1:0]  flits_a, flits_d;
  logic [WQ_W-1:0]    w_a;
  logic [M_W-1:0]     m_a, m_b;
  logic [DIST_W-1:0]  dist_a;
  logic [HW-1:0]      dw_d, dw_b, hops_b;
  logic [FS_W-1:0]    span;
  logic [FH_W-1:0]    fh_b, fh_c;
  logic [LO_W-1:0]    hl_c, dl_c;
  logic [HH_W-1:0]    hh_c, dh_c;
  logic [SUM_W-1:0]   lat_sum, con_sum;
  logic               valid_q;
  logic [OUT_W-1:0]   lat_q, con_q, fh_q;

  assign flits_d = FLIT_W'(quo_i) + FLIT_W'(rem_i != '0);
  assign span    = FS_W'(dist_a) + FS_W'(flits_a);
  assign dw_d    = HW'(dist_a) * HW'(w_a);

  assign lat_sum = {1'b0, hh_c, 8'b0} + SUM_W'(hl_c[LO_W-1:M_W]) + SUM_W'(hl_c[M_W-1:0] != '0);
  assign con_sum = {1'b0, dh_c, 8'b0} + SUM_W'(dl_c[LO_W-1:M_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a   <= '0;
      ctl_b   <= '0;
      ctl_c   <= '0;
      valid_q <= 1'b0;
    end else if (ce_i) begin
      ctl_a   <= ctl_i;
      ctl_b   <= ctl_a;
      ctl_c   <= ctl_b;
      valid_q <= ctl_c.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      flits_a <= flits_d;
      w_a     <= WQ_W'(cf_i) * WQ_W'(flits_d);
      m_a     <= M_W'(wire_delay_i) * M_W'(hop_time_i);
      dist_a  <= dist_i;
      dw_b    <= dw_d;
      hops_b  <= dw_d + (HW'(span) << 16);
      fh_b    <= FH_W'(flits_a) * FH_W'(span);
      m_b     <= m_a;
      hl_c    <= LO_W'(hops_b[31:0]) * LO_W'(m_b);
      hh_c    <= HH_W'(hops_b[HW-1:32]) * HH_W'(m_b);
      dl_c    <= LO_W'(dw_b[31:0]) * LO_W'(m_b);
      dh_c    <= HH_W'(dw_b[HW-1:32]) * HH_W'(m_b);
      fh_c    <= fh_b;
      if (ctl_c.zero) begin
        lat_q <= '0;
        con_q <= '0;
        fh_q  <= '0;
      end else begin
        lat_q <= (lat_sum > SUM_W'(32'hFFFF_FFFF)) ? '1 : lat_sum[OUT_W-1:0];
        con_q <= (con_sum > SUM_W'(32'hFFFF_FFFF)) ? '1 : con_sum[OUT_W-1:0];
        fh_q  <= (fh_c > FH_W'(32'hFFFF_FFFF)) ? '1 : fh_c[OUT_W-1:0];
      end
    end
  end

  assign valid_o      = valid_q;
  assign latency_o    = lat_q;
  assign contention_o = con_q;
  assign flit_hops_o  = fh_q;

endmodule

// ===== rtl/core/mesh_packet_latency_model_unit.sv =====
// Top level of the mesh packet latency model.
// Usage: each input beat carries sender node, receiver node and byte length;
// each output beat carries latency, contention cycles and flit hops of one
// packet, in arrival order. Both channels are valid/ready.
// Configuration goes through cfg_we_i, cfg_index_i, cfg_data_i; write it only
// while no packet is in flight.
// Pipeline: the chain of division cells takes one quotient bit per cell
// for the flit count and for each radix digit of the node numbers; four
// stages follow for the multiplies, rounding and output.
// Throughput: one packet per cycle while the output beat is taken.
// Reset: all pipeline valids clear and configuration registers take their
// reset values; the block is ready right after reset.
// Stall: when the output beat is not taken, the whole pipeline holds and
// in_ready_o drops until the beat leaves.
module mesh_packet_latency_model_unit import mplm_pkg::*; #(
  parameter int MAX_DIMS  = 4,
  parameter int NODE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [NODE_BITS-1:0]  sender_node_i,
  input  logic [NODE_BITS-1:0]  receiver_node_i,
  input  logic [LEN_W-1:0]      length_bytes_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_W-1:0]      latency_cycles_o,
  output logic [OUT_W-1:0]      contention_cycles_o,
  output logic [OUT_W-1:0]      flit_hops_o
);

  localparam int NODE_STEPS = NODE_BITS * MAX_DIMS;
  localparam int NCELL      = (NODE_STEPS > FLIT_STEPS) ? NODE_STEPS : FLIT_STEPS;
  localparam int DIST_W     = 8 + $clog2(MAX_DIMS + 1);

  logic                enabled_q;
  logic [WD_W-1:0]     wire_delay_q;
  logic [HT_W-1:0]     hop_time_q;
  logic [DIMS_W-1:0]   dimensions_q;
  logic [RADIX_W-1:0]  radix_q;
  logic [CW_W-1:0]     channel_width_q;
  logic [CF_W-1:0]     contention_factor_q;
  logic [CW_W-1:0]     width_eff;
  logic                ce;

  mplm_ctl_t             ctl_c  [NCELL+1];
  logic [FLIT_DIV_W-1:0] lx_c   [NCELL+1];
  logic [CW_W-1:0]       lr_c   [NCELL+1];
  logic [NODE_BITS-1:0]  sx_c   [NCELL+1];
  logic [NODE_BITS-1:0]  dx_c   [NCELL+1];
  logic [RADIX_W-1:0]    sr_c   [NCELL+1];
  logic [RADIX_W-1:0]    dr_c   [NCELL+1];
  logic [DIST_W-1:0]     dist_c [NCELL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q           <= 1'b0;
      wire_delay_q        <= 8'd1;
      hop_time_q          <= 16'd512;
      dimensions_q        <= 3'd2;
      radix_q             <= 9'd8;
      channel_width_q     <= 9'd32;
      contention_factor_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENABLED:           enabled_q           <= cfg_data_i[0];
        REG_WIRE_DELAY:        wire_delay_q        <= cfg_data_i[WD_W-1:0];
        REG_HOP_TIME_Q8:       hop_time_q          <= cfg_data_i[HT_W-1:0];
        REG_DIMENSIONS:        dimensions_q        <= cfg_data_i[DIMS_W-1:0];
        REG_RADIX:             radix_q             <= cfg_data_i[RADIX_W-1:0];
        REG_CHANNEL_WIDTH:     channel_width_q     <= cfg_data_i[CW_W-1:0];
        REG_CONTENTION_FACTOR: contention_factor_q <= cfg_data_i[CF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign width_eff  = (channel_width_q == '0) ? CW_W'(1) : channel_width_q;
  assign ce         = !out_valid_o || out_ready_i;
  assign in_ready_o = ce;

  assign ctl_c[0].valid = in_valid_i;
  assign ctl_c[0].zero  = !enabled_q || (sender_node_i == receiver_node_i);
  assign lx_c[0]        = {length_bytes_i, 3'b000};
  assign lr_c[0]        = '0;
  assign sx_c[0]        = sender_node_i;
  assign dx_c[0]        = receiver_node_i;
  assign sr_c[0]        = '0;
  assign dr_c[0]        = '0;
  assign dist_c[0]      = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    mplm_cell #(
      .IDX       (g),
      .NODE_BITS (NODE_BITS),
      .MAX_DIMS  (MAX_DIMS),
      .DIST_W    (DIST_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .radix_i (radix_q),
      .width_i (width_eff),
      .dims_i  (dimensions_q),
      .ctl_i   (ctl_c[g]),
      .lx_i    (lx_c[g]),
      .lr_i    (lr_c[g]),
      .sx_i    (sx_c[g]),
      .dx_i    (dx_c[g]),
      .sr_i    (sr_c[g]),
      .dr_i    (dr_c[g]),
      .dist_i  (dist_c[g]),
      .ctl_o   (ctl_c[g+1]),
      .lx_o    (lx_c[g+1]),
      .lr_o    (lr_c[g+1]),
      .sx_o    (sx_c[g+1]),
      .dx_o    (dx_c[g+1]),
      .sr_o    (sr_c[g+1]),
      .dr_o    (dr_c[g+1]),
      .dist_o  (dist_c[g+1])
    );
  end

  mplm_arith #(
    .DIST_W (DIST_W)
  ) u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ce_i         (ce),
    .wire_delay_i (wire_delay_q),
    .hop_time_i   (hop_time_q),
    .cf_i         (contention_factor_q),
    .ctl_i        (ctl_c[NCELL]),
    .quo_i        (lx_c[NCELL]),
    .rem_i        (lr_c[NCELL]),
    .dist_i       (dist_c[NCELL]),
    .valid_o      (out_valid_o),
    .latency_o    (latency_cycles_o),
    .contention_o (contention_cycles_o),
    .flit_hops_o  (flit_hops_o)
  );

  a_con_le_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (contention_cycles_o <= latency_cycles_o))
    else $error("contention exceeds latency");

  a_stall_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending output beat");

  a_con_needs_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (contention_cycles_o != '0)) |-> (contention_factor_q != '0))
    else $error("contention without contention factor");

endmodule

// ===== tb/mesh_packet_latency_model_checker.sv =====
// Checker for the mesh packet latency model: tracks config, predicts and compares results.
module mesh_packet_latency_model_checker import mplm_pkg::*; #(
  parameter int MAX_DIMS  = 4,
  parameter int NODE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [NODE_BITS-1:0]  sender_node_i,
  input  logic [NODE_BITS-1:0]  receiver_node_i,
  input  logic [LEN_W-1:0]      length_bytes_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_W-1:0]      latency_cycles_i,
  input  logic [OUT_W-1:0]      contention_cycles_i,
  input  logic [OUT_W-1:0]      flit_hops_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic            enabled;
    logic [WD_W-1:0] wire_delay;
    logic [HT_W-1:0] hop_time_q8;
    logic [DIMS_W-1:0] dimensions;
    logic [RADIX_W-1:0] radix;
    logic [CW_W-1:0] channel_width;
    logic [CF_W-1:0] contention_factor;
  } model_cfg_t;

  typedef struct {
    logic [OUT_W-1:0] latency;
    logic [OUT_W-1:0] contention;
    logic [OUT_W-1:0] flit_hops;
  } packet_cost_t;

  model_cfg_t   cfg;
  packet_cost_t cost_queue[$];

  function automatic logic [OUT_W-1:0] clamp32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic packet_cost_t predict_cost(model_cfg_t c, logic [NODE_BITS-1:0] s,
                                                logic [NODE_BITS-1:0] d, logic [LEN_W-1:0] len);
    longint unsigned width, flits, hop_sum, dims, k, src, dst, r1, r2, wq, hq, m, v;
    logic [127:0] prod;
    packet_cost_t r;
    r = '{default: '0};
    if (!c.enabled || s == d) return r;
    width = (c.channel_width == 0) ? 1 : longint'(c.channel_width);
    flits = (longint'(len) * 8 + width - 1) / width;
    hop_sum = 0;
    dims = (c.dimensions > MAX_DIMS) ? MAX_DIMS : longint'(c.dimensions);
    k = c.radix;
    src = s;
    dst = d;
    if (k >= 2) begin
      for (int i = 0; i < dims; i++) begin
        r1 = src % k;
        r2 = dst % k;
        hop_sum += (r1 > r2) ? k - (r1 - r2) : r2 - r1;
        src /= k;
        dst /= k;
      end
    end
    wq = longint'(c.contention_factor) * flits;
    hq = hop_sum * (65536 + wq) + (flits << 16);
    m = longint'(c.wire_delay) * longint'(c.hop_time_q8);
    prod = 128'(hq) * 128'(m);
    v = prod[87:24];
    if (|prod[23:0]) v += 1;
    r.latency = clamp32(v);
    prod = 128'(hop_sum * wq) * 128'(m);
    r.contention = clamp32(prod[87:24]);
    r.flit_hops = clamp32(flits * (hop_sum + flits));
    return r;
  endfunction

  assign pending_o = cost_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    packet_cost_t e;
    if (!rst_ni) begin
      cfg <= '{enabled: 1'b0, wire_delay: 8'd1, hop_time_q8: 16'd512, dimensions: 3'd2,
               radix: 9'd8, channel_width: 9'd32, contention_factor: 16'd0};
      cost_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cost_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat at %0t", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = cost_queue.pop_front();
          if (e.latency !== latency_cycles_i || e.contention !== contention_cycles_i ||
              e.flit_hops !== flit_hops_i) begin
            if (fail_count_o < 10)
              $display("mismatch at %0t: exp lat %0d cont %0d fh %0d, got %0d %0d %0d",
                       $realtime, e.latency, e.contention, e.flit_hops,
                       latency_cycles_i, contention_cycles_i, flit_hops_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        cost_queue = {cost_queue,
                      predict_cost(cfg, sender_node_i, receiver_node_i, length_bytes_i)};
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLED:           cfg.enabled <= cfg_data_i[0];
          REG_WIRE_DELAY:        cfg.wire_delay <= cfg_data_i[WD_W-1:0];
          REG_HOP_TIME_Q8:       cfg.hop_time_q8 <= cfg_data_i[HT_W-1:0];
          REG_DIMENSIONS:        cfg.dimensions <= cfg_data_i[DIMS_W-1:0];
          REG_RADIX:             cfg.radix <= cfg_data_i[RADIX_W-1:0];
          REG_CHANNEL_WIDTH:     cfg.channel_width <= cfg_data_i[CW_W-1:0];
          REG_CONTENTION_FACTOR: cfg.contention_factor <= cfg_data_i[CF_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/mesh_packet_latency_model_unit_tb.sv =====
// Testbench top for the mesh packet latency model: stimulus, watchdog and verdict.
module mesh_packet_latency_model_unit_tb import mplm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_BITS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [NODE_BITS-1:0] sender_node_i = '0;
  logic [NODE_BITS-1:0] receiver_node_i = '0;
  logic [LEN_W-1:0] length_bytes_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OUT_W-1:0] latency_cycles_o, contention_cycles_o, flit_hops_o;
  int fail_count, pending, idle_cycles;
  int ready_hold;

  always #4 clk_i = ~clk_i;

  mesh_packet_latency_model_unit dut (.*);

  mesh_packet_latency_model_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .sender_node_i, .receiver_node_i, .length_bytes_i,
    .out_valid_i(out_valid_o), .out_ready_i, .latency_cycles_i(latency_cycles_o),
    .contention_cycles_i(contention_cycles_o), .flit_hops_i(flit_hops_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 7);
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 4);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_model(logic en, logic [15:0] wd, logic [15:0] ht, logic [15:0] dims,
                           logic [15:0] rad, logic [15:0] cw, logic [15:0] cf);
    drain();
    write_reg(REG_ENABLED, CFG_DATA_W'(en));
    write_reg(REG_WIRE_DELAY, wd);
    write_reg(REG_HOP_TIME_Q8, ht);
    write_reg(REG_DIMENSIONS, dims);
    write_reg(REG_RADIX, rad);
    write_reg(REG_CHANNEL_WIDTH, cw);
    write_reg(REG_CONTENTION_FACTOR, cf);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_packet(logic [15:0] s, logic [15:0] d, logic [15:0] len, bit no_gaps);
    int gap;
    sender_node_i <= s;
    receiver_node_i <= d;
    length_bytes_i <= len;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2:  gap = $urandom_range(1, 3);
        3:        gap = $urandom_range(10, 60);
        default:  gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_packet(bit no_gaps);
    logic [15:0] s, d, len;
    s = 16'($urandom);
    d = ($urandom_range(0, 9) == 0) ? s : 16'($urandom);
    case ($urandom_range(0, 9))
      0:       len = 16'hFFFF;
      1:       len = 16'd0;
      2, 3, 4: len = 16'($urandom_range(1, 64));
      default: len = 16'($urandom);
    endcase
    send_packet(s, d, len, no_gaps);
  endtask

  initial begin
    bit calm;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_packet(16'd1, 16'd2, 16'd100, 1'b0);
    send_packet(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
    set_model(1'b1, 16'd1, 16'd512, 16'd2, 16'd8, 16'd32, 16'd0);
    send_packet(16'd0, 16'd1, 16'd0, 1'b0);
    send_packet(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_packet(16'hFFFF, 16'd0, 16'd1, 1'b0);
    send_packet(16'd7, 16'd0, 16'd8, 1'b0);
    send_packet(16'd42, 16'd42, 16'd500, 1'b0);
    send_packet(16'd63, 16'd9, 16'd33, 1'b0);
    set_model(1'b1, 16'd255, 16'hFFFF, 16'd7, 16'd256, 16'd0, 16'hFFFF);
    send_packet(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_packet(16'h1234, 16'h8765, 16'd1000, 1'b0);
    send_packet(16'h00FF, 16'hFF00, 16'd1, 1'b0);
    set_model(1'b1, 16'd3, 16'd300, 16'd0, 16'd1, 16'd511, 16'd1);
    send_packet(16'd5, 16'd9, 16'd200, 1'b0);
    send_packet(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0);
    set_model(1'b1, 16'd0, 16'd0, 16'd4, 16'd2, 16'd1, 16'd65535);
    send_packet(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
    send_packet(16'h0F0F, 16'hF0F0, 16'd7, 1'b0);
    set_model(1'b1, 16'd255, 16'hFFFF, 16'd1, 16'd511, 16'd256, 16'd0);
    send_packet(16'd0, 16'd510, 16'd3, 1'b0);
    send_packet(16'd510, 16'd0, 16'd4, 1'b0);

    for (int p = 0; p < 12; p++) begin
      set_model($urandom_range(0, 9) != 0,
                ($urandom_range(0, 4) == 0) ? 16'd255 : 16'($urandom_range(0, 255)),
                ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 7)), 16'($urandom_range(0, 511)),
                16'($urandom_range(0, 511)),
                ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
      calm = 1'b0;
      for (int n = 0; n < 120; n++) begin
        if (n % 30 == 0) calm = ($urandom_range(0, 2) == 0);
        if (p == 5 && n == 60) drain();
        random_packet(calm);
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/mplm_pkg.sv
rtl/core/mplm_cell.sv
rtl/core/mplm_arith.sv
rtl/core/mesh_packet_latency_model_unit.sv
tb/mesh_packet_latency_model_checker.sv
tb/mesh_packet_latency_model_unit_tb.sv
